// ===== src/u8tc_pkg.sv =====
// Types and constants shared by the UTF-8 text class counter.
// No dependencies; compile first.
package u8tc_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [20:0] codepoint_t;
    typedef logic [31:0] count_word_t;
    typedef logic [2:0]  seq_len_t;

    localparam seq_len_t SEQ_NONE = 3'd0;
    localparam seq_len_t SEQ_LEN2 = 3'd2;
    localparam seq_len_t SEQ_LEN3 = 3'd3;
    localparam seq_len_t SEQ_LEN4 = 3'd4;

    localparam byte_t CONT_MASK  = 8'hC0;
    localparam byte_t CONT_CODE  = 8'h80;
    localparam byte_t LEAD2_MASK = 8'hE0;
    localparam byte_t LEAD2_CODE = 8'hC0;
    localparam byte_t LEAD3_MASK = 8'hF0;
    localparam byte_t LEAD3_CODE = 8'hE0;
    localparam byte_t LEAD4_MASK = 8'hF8;
    localparam byte_t LEAD4_CODE = 8'hF0;

    localparam codepoint_t CP_MIN2    = 21'h00080;
    localparam codepoint_t CP_MIN3    = 21'h00800;
    localparam codepoint_t CP_MIN4    = 21'h10000;
    localparam codepoint_t CP_MAX     = 21'h10FFFF;
    localparam codepoint_t SURR_LO    = 21'h0D800;
    localparam codepoint_t SURR_HI    = 21'h0DFFF;

    localparam codepoint_t IDEO_A_LO  = 21'h03400;
    localparam codepoint_t IDEO_A_HI  = 21'h04DBF;
    localparam codepoint_t IDEO_U_LO  = 21'h04E00;
    localparam codepoint_t IDEO_U_HI  = 21'h09FFF;
    localparam codepoint_t IDEO_B_LO  = 21'h20000;
    localparam codepoint_t IDEO_B_HI  = 21'h2A6DF;
    localparam codepoint_t IDEO_CF_LO = 21'h2A700;
    localparam codepoint_t IDEO_CF_HI = 21'h2EBE0;
    localparam codepoint_t IDEO_S_LO  = 21'h2F800;
    localparam codepoint_t IDEO_S_HI  = 21'h2FA1F;

    localparam codepoint_t CP_APOSTROPHE = 21'h00027;
    localparam codepoint_t CP_DIGIT_LO   = 21'h00030;
    localparam codepoint_t CP_DIGIT_HI   = 21'h00039;
    localparam codepoint_t CP_UPPER_LO   = 21'h00041;
    localparam codepoint_t CP_UPPER_HI   = 21'h0005A;
    localparam codepoint_t CP_LOWER_LO   = 21'h00061;
    localparam codepoint_t CP_LOWER_HI   = 21'h0007A;

    localparam int PUNCT_NUM = 33;

    localparam codepoint_t PUNCT_LIST [PUNCT_NUM] = '{
        21'h03001, 21'h03002, 21'h0FF0C, 21'h0FF1B, 21'h0FF1A, 21'h0FF01, 21'h0FF1F,
        21'h0201C, 21'h0201D, 21'h02018, 21'h02019, 21'h0FF08, 21'h0FF09, 21'h03010,
        21'h03011, 21'h0300A, 21'h0300B, 21'h02014, 21'h02026, 21'h000B7, 21'h0300C,
        21'h0300D, 21'h0300E, 21'h0300F, 21'h03014, 21'h03015, 21'h03016, 21'h03017,
        21'h0301A, 21'h0301B, 21'h03000, 21'h0FFE5, 21'h0203B
    };

endpackage

// ===== src/u8tc_byte_if.sv =====
// Byte channel of the UTF-8 text class counter: valid/ready plus one text byte.
// Depends on u8tc_pkg.
interface u8tc_byte_if;

    logic              valid;
    logic              ready;
    u8tc_pkg::byte_t   byte_value;
    logic              last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);

endinterface

// ===== src/u8tc_count_if.sv =====
// Count channel of the UTF-8 text class counter: valid/ready plus five counts.
// Depends on u8tc_pkg.
interface u8tc_count_if;

    logic                    valid;
    logic                    ready;
    u8tc_pkg::count_word_t   ideograph_count;
    u8tc_pkg::count_word_t   punct_count;
    u8tc_pkg::count_word_t   word_count;
    u8tc_pkg::count_word_t   word_char_count;
    u8tc_pkg::count_word_t   codepoint_count;

    modport source (
        output valid, output ideograph_count, output punct_count, output word_count,
        output word_char_count, output codepoint_count, input ready
    );
    modport sink (
        input valid, input ideograph_count, input punct_count, input word_count,
        input word_char_count, input codepoint_count, output ready
    );

endinterface

// ===== src/utf8_text_class_counter_core.sv =====
// UTF-8 text class counter: strict decoder, classifier and saturating counts.
// A byte waits in the input register and updates the counts as it advances; on the last
// byte the counts clear and the count word is loaded into the output register. One byte per cycle,
// held up only when a last byte meets an output register that is full and not taken.
// Reset clears the decoder state, the counts and both valid flags at once.
// Depends on u8tc_pkg, u8tc_byte_if, u8tc_count_if.
module utf8_text_class_counter_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    u8tc_byte_if.sink           text,
    u8tc_count_if.source        counts
);

    typedef logic [COUNT_WIDTH-1:0] total_t;

    function automatic total_t sat_inc(input total_t c, input logic hit);
        total_t r;
        r = c;
        if (hit && !(&c))
        begin
            r = c + COUNT_WIDTH'(1);
        end
        return r;
    endfunction

    function automatic u8tc_pkg::count_word_t low_word(input total_t c);
        logic [COUNT_WIDTH+31:0] wide;
        wide = {32'd0, c};
        return wide[31:0];
    endfunction

    function automatic logic in_rng(input u8tc_pkg::codepoint_t v,
                                    input u8tc_pkg::codepoint_t lo,
                                    input u8tc_pkg::codepoint_t hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // input register
    logic                   s1_valid_reg;
    u8tc_pkg::byte_t        s1_byte_reg;
    logic                   s1_last_reg;
    logic                   advance;

    // decoder state
    u8tc_pkg::seq_len_t     seq_len_reg;
    u8tc_pkg::seq_len_t     seq_len_next;
    logic [2:0]             rcv_reg;
    logic [2:0]             rcv_next;
    u8tc_pkg::codepoint_t   partial_reg;
    u8tc_pkg::codepoint_t   partial_next;
    logic                   inside_word_reg;
    logic                   inside_word_next;

    total_t ideo_total_reg, punct_total_reg, word_total_reg;
    total_t word_char_total_reg, cp_total_reg;
    total_t ideo_total_next, punct_total_next, word_total_next;
    total_t word_char_total_next, cp_total_next;

    // output register
    logic                   out_valid_reg;
    u8tc_pkg::count_word_t  out_ideo_reg, out_punct_reg, out_word_reg;
    u8tc_pkg::count_word_t  out_word_char_reg, out_cp_reg;

    logic                   cp_valid;
    u8tc_pkg::codepoint_t   cp;
    u8tc_pkg::codepoint_t   shifted;
    logic [2:0]             rcv_inc;
    logic                   is_cont;
    logic                   is_ideo;
    logic                   is_punct;
    logic                   is_word;
    logic                   ideo_hit, punct_hit, word_hit, word_start;

    assign advance    = s1_valid_reg && (!s1_last_reg || !out_valid_reg || counts.ready);
    assign text.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            s1_valid_reg <= text.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.ready && text.valid)
        begin
            s1_byte_reg <= text.byte_value;
            s1_last_reg <= text.last_byte;
        end
    end

    // decode
    assign is_cont = (s1_byte_reg & u8tc_pkg::CONT_MASK) == u8tc_pkg::CONT_CODE;
    assign shifted = {partial_reg[14:0], s1_byte_reg[5:0]};
    assign rcv_inc = rcv_reg + 3'd1;

    always_comb
    begin
        seq_len_next = u8tc_pkg::SEQ_NONE;
        rcv_next     = 3'd0;
        partial_next = '0;
        cp_valid     = 1'b0;
        cp           = shifted;
        if (seq_len_reg != u8tc_pkg::SEQ_NONE && is_cont)
        begin
            if (rcv_inc >= seq_len_reg)
            begin
                case (seq_len_reg)
                    u8tc_pkg::SEQ_LEN2: cp_valid = shifted >= u8tc_pkg::CP_MIN2;
                    u8tc_pkg::SEQ_LEN3: cp_valid = (shifted >= u8tc_pkg::CP_MIN3) &&
                        !in_rng(shifted, u8tc_pkg::SURR_LO, u8tc_pkg::SURR_HI);
                    default:            cp_valid = (shifted >= u8tc_pkg::CP_MIN4) &&
                        (shifted <= u8tc_pkg::CP_MAX);
                endcase
            end
            else
            begin
                seq_len_next = seq_len_reg;
                rcv_next     = rcv_inc;
                partial_next = shifted;
            end
        end
        else if (!s1_byte_reg[7])
        begin
            cp_valid = 1'b1;
            cp       = {13'd0, s1_byte_reg};
        end
        else if ((s1_byte_reg & u8tc_pkg::LEAD2_MASK) == u8tc_pkg::LEAD2_CODE)
        begin
            seq_len_next = u8tc_pkg::SEQ_LEN2;
            rcv_next     = 3'd1;
            partial_next = {16'd0, s1_byte_reg[4:0]};
        end
        else if ((s1_byte_reg & u8tc_pkg::LEAD3_MASK) == u8tc_pkg::LEAD3_CODE)
        begin
            seq_len_next = u8tc_pkg::SEQ_LEN3;
            rcv_next     = 3'd1;
            partial_next = {17'd0, s1_byte_reg[3:0]};
        end
        else if ((s1_byte_reg & u8tc_pkg::LEAD4_MASK) == u8tc_pkg::LEAD4_CODE)
        begin
            seq_len_next = u8tc_pkg::SEQ_LEN4;
            rcv_next     = 3'd1;
            partial_next = {18'd0, s1_byte_reg[2:0]};
        end
    end

    // classify
    assign is_ideo = in_rng(cp, u8tc_pkg::IDEO_A_LO,  u8tc_pkg::IDEO_A_HI)  ||
                     in_rng(cp, u8tc_pkg::IDEO_U_LO,  u8tc_pkg::IDEO_U_HI)  ||
                     in_rng(cp, u8tc_pkg::IDEO_B_LO,  u8tc_pkg::IDEO_B_HI)  ||
                     in_rng(cp, u8tc_pkg::IDEO_CF_LO, u8tc_pkg::IDEO_CF_HI) ||
                     in_rng(cp, u8tc_pkg::IDEO_S_LO,  u8tc_pkg::IDEO_S_HI);

    always_comb
    begin
        is_punct = 1'b0;
        for (int i = 0; i < u8tc_pkg::PUNCT_NUM; i++)
        begin
            if (cp == u8tc_pkg::PUNCT_LIST[i])
            begin
                is_punct = 1'b1;
            end
        end
    end

    assign is_word = in_rng(cp, u8tc_pkg::CP_LOWER_LO, u8tc_pkg::CP_LOWER_HI) ||
                     in_rng(cp, u8tc_pkg::CP_UPPER_LO, u8tc_pkg::CP_UPPER_HI) ||
                     in_rng(cp, u8tc_pkg::CP_DIGIT_LO, u8tc_pkg::CP_DIGIT_HI) ||
                     (cp == u8tc_pkg::CP_APOSTROPHE);

    assign ideo_hit   = cp_valid && is_ideo;
    assign punct_hit  = cp_valid && !is_ideo && is_punct;
    assign word_hit   = cp_valid && !is_ideo && !is_punct && is_word;
    assign word_start = word_hit && !inside_word_reg;

    assign inside_word_next     = cp_valid ? word_hit : inside_word_reg;
    assign ideo_total_next      = sat_inc(ideo_total_reg, ideo_hit);
    assign punct_total_next     = sat_inc(punct_total_reg, punct_hit);
    assign word_total_next      = sat_inc(word_total_reg, word_start);
    assign word_char_total_next = sat_inc(word_char_total_reg, word_hit);
    assign cp_total_next        = sat_inc(cp_total_reg, cp_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg         <= u8tc_pkg::SEQ_NONE;
            rcv_reg             <= 3'd0;
            partial_reg         <= '0;
            inside_word_reg     <= 1'b0;
            ideo_total_reg      <= '0;
            punct_total_reg     <= '0;
            word_total_reg      <= '0;
            word_char_total_reg <= '0;
            cp_total_reg        <= '0;
        end
        else if (advance)
        begin
            if (s1_last_reg)
            begin
                seq_len_reg         <= u8tc_pkg::SEQ_NONE;
                rcv_reg             <= 3'd0;
                partial_reg         <= '0;
                inside_word_reg     <= 1'b0;
                ideo_total_reg      <= '0;
                punct_total_reg     <= '0;
                word_total_reg      <= '0;
                word_char_total_reg <= '0;
                cp_total_reg        <= '0;
            end
            else
            begin
                seq_len_reg         <= seq_len_next;
                rcv_reg             <= rcv_next;
                partial_reg         <= partial_next;
                inside_word_reg     <= inside_word_next;
                ideo_total_reg      <= ideo_total_next;
                punct_total_reg     <= punct_total_next;
                word_total_reg      <= word_total_next;
                word_char_total_reg <= word_char_total_next;
                cp_total_reg        <= cp_total_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (counts.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_last_reg)
        begin
            out_ideo_reg      <= low_word(ideo_total_next);
            out_punct_reg     <= low_word(punct_total_next);
            out_word_reg      <= low_word(word_total_next);
            out_word_char_reg <= low_word(word_char_total_next);
            out_cp_reg        <= low_word(cp_total_next);
        end
    end

    assign counts.valid           = out_valid_reg;
    assign counts.ideograph_count = out_ideo_reg;
    assign counts.punct_count     = out_punct_reg;
    assign counts.word_count      = out_word_reg;
    assign counts.word_char_count = out_word_char_reg;
    assign counts.codepoint_count = out_cp_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        seq_len_reg == u8tc_pkg::SEQ_NONE || seq_len_reg == u8tc_pkg::SEQ_LEN2 ||
        seq_len_reg == u8tc_pkg::SEQ_LEN3 || seq_len_reg == u8tc_pkg::SEQ_LEN4)
        else $error("illegal sequence length");

    assert property (@(posedge clk) disable iff (!rst_n)
        seq_len_reg != u8tc_pkg::SEQ_NONE |-> rcv_reg != 3'd0 && rcv_reg < seq_len_reg)
        else $error("received byte count out of step with sequence length");

    assert property (@(posedge clk) disable iff (!rst_n)
        seq_len_reg == u8tc_pkg::SEQ_NONE |-> rcv_reg == 3'd0 && partial_reg == '0)
        else $error("stale decoder state with no sequence open");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_last_reg |=> out_valid_reg && cp_total_reg == '0 &&
        word_total_reg == '0 && !inside_word_reg)
        else $error("counts not emitted and cleared after last byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        word_total_reg <= word_char_total_reg && word_char_total_reg <= cp_total_reg)
        else $error("word counts exceed their bounds");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for utf8_text_class_counter_core: random UTF-8 texts with noise, checked
// per text against a built-in decoder and class counter. Depends on u8tc_pkg and the RTL.
module testbench;
    import u8tc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int OPENING_LEN  = 26;

    localparam byte_t OPENING_TEXT [OPENING_LEN] = '{
        8'h41, 8'h7A, 8'h80, 8'h27, 8'h30, 8'h00, 8'hC0, 8'h80, 8'hED, 8'hA0,
        8'h80, 8'hF4, 8'h90, 8'h80, 8'h80, 8'hFF, 8'hE4, 8'h39, 8'hE4, 8'hB8,
        8'h80, 8'hE3, 8'h80, 8'h81, 8'hE4, 8'hB8
    };

    localparam int EDGE_NUM = 30;
    localparam codepoint_t EDGE_POINTS [EDGE_NUM] = '{
        21'h0007F, 21'h00080, 21'h007FF, 21'h00800, 21'h0D7FF, 21'h0E000, 21'h0FFFF,
        21'h10000, 21'h10FFFF, 21'h033FF, 21'h04DC0, 21'h04DFF, 21'h0A000, 21'h1FFFF,
        21'h2A6E0, 21'h2A6FF, 21'h2EBE1, 21'h2F7FF, 21'h2FA20, 21'h0FF0B, 21'h000B6,
        21'h02FFF, 21'h00026, 21'h00028, 21'h0002F, 21'h0003A, 21'h00040, 21'h0005B,
        21'h00060, 21'h0007B
    };

    typedef struct packed {
        byte_t value;
        logic  last;
    } text_word_t;

    typedef struct packed {
        count_word_t ideographs;
        count_word_t puncts;
        count_word_t words;
        count_word_t word_chars;
        count_word_t codepoints;
    } tally_t;

    logic clk;
    logic rst_n;

    u8tc_byte_if  text ();
    u8tc_count_if counts ();

    utf8_text_class_counter_core #(
        .COUNT_WIDTH(32)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .counts (counts)
    );

    text_word_t  pending_words [$];
    tally_t      expected_tallies [$];
    byte_t       draft [$];
    text_word_t  outgoing;

    tally_t      running;
    codepoint_t  dec_partial;
    seq_len_t    dec_len;
    seq_len_t    dec_seen;
    logic        in_word_run;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_request = 1'b0;
    int          hold_left;
    int          errors = 0;
    int          cycles = 0;

    function automatic count_word_t sat_inc(count_word_t c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic logic in_span(codepoint_t cp, codepoint_t lo, codepoint_t hi);
        return cp >= lo && cp <= hi;
    endfunction

    function automatic void clear_sequence();
        dec_partial = '0;
        dec_len     = SEQ_NONE;
        dec_seen    = '0;
    endfunction

    function automatic void reset_predictor();
        clear_sequence();
        in_word_run = 1'b0;
        running     = '0;
    endfunction

    function automatic void tally_codepoint(codepoint_t cp);
        logic punct_hit;
        punct_hit = 1'b0;
        for (int k = 0; k < PUNCT_NUM; k++)
            if (PUNCT_LIST[k] == cp)
                punct_hit = 1'b1;
        running.codepoints = sat_inc(running.codepoints);
        if (in_span(cp, IDEO_U_LO, IDEO_U_HI) || in_span(cp, IDEO_A_LO, IDEO_A_HI) ||
            in_span(cp, IDEO_B_LO, IDEO_B_HI) || in_span(cp, IDEO_CF_LO, IDEO_CF_HI) ||
            in_span(cp, IDEO_S_LO, IDEO_S_HI))
        begin
            running.ideographs = sat_inc(running.ideographs);
            in_word_run = 1'b0;
        end
        else if (punct_hit)
        begin
            running.puncts = sat_inc(running.puncts);
            in_word_run = 1'b0;
        end
        else if (in_span(cp, CP_LOWER_LO, CP_LOWER_HI) || in_span(cp, CP_UPPER_LO, CP_UPPER_HI) ||
                 in_span(cp, CP_DIGIT_LO, CP_DIGIT_HI) || cp == CP_APOSTROPHE)
        begin
            if (!in_word_run)
            begin
                running.words = sat_inc(running.words);
                in_word_run = 1'b1;
            end
            running.word_chars = sat_inc(running.word_chars);
        end
        else
            in_word_run = 1'b0;
    endfunction

    function automatic void open_lead(byte_t b);
        clear_sequence();
        if (b[7] == 1'b0)
            tally_codepoint({13'd0, b});
        else if ((b & LEAD2_MASK) == LEAD2_CODE)
        begin
            dec_partial = {16'd0, b[4:0]};
            dec_len     = SEQ_LEN2;
            dec_seen    = 3'd1;
        end
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
        begin
            dec_partial = {17'd0, b[3:0]};
            dec_len     = SEQ_LEN3;
            dec_seen    = 3'd1;
        end
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
        begin
            dec_partial = {18'd0, b[2:0]};
            dec_len     = SEQ_LEN4;
            dec_seen    = 3'd1;
        end
    endfunction

    function automatic void absorb_word(text_word_t w);
        codepoint_t cp;
        seq_len_t   len;
        logic       ok;
        if (dec_len != SEQ_NONE && (w.value & CONT_MASK) == CONT_CODE)
        begin
            dec_partial = {dec_partial[14:0], w.value[5:0]};
            dec_seen    = dec_seen + 1'b1;
            if (dec_seen >= dec_len)
            begin
                cp  = dec_partial;
                len = dec_len;
                clear_sequence();
                if (len == SEQ_LEN2)
                    ok = cp >= CP_MIN2;
                else if (len == SEQ_LEN3)
                    ok = cp >= CP_MIN3 && !in_span(cp, SURR_LO, SURR_HI);
                else
                    ok = cp >= CP_MIN4 && cp <= CP_MAX;
                if (ok)
                    tally_codepoint(cp);
            end
        end
        else
            open_lead(w.value);
        if (w.last)
        begin
            expected_tallies.push_back(running);
            reset_predictor();
        end
    endfunction

    function automatic codepoint_t span_pick(codepoint_t lo, codepoint_t hi);
        case ($urandom_range(7))
            0: return lo;
            1: return hi;
            default: return codepoint_t'($urandom_range(hi, lo));
        endcase
    endfunction

    function automatic codepoint_t first_of_len(int len);
        if (len == 2)
            return CP_MIN2;
        else if (len == 3)
            return CP_MIN3;
        return CP_MIN4;
    endfunction

    function automatic codepoint_t last_of_len(int len);
        if (len == 2)
            return CP_MIN3 - 1'b1;
        else if (len == 3)
            return CP_MIN4 - 1'b1;
        return CP_MAX;
    endfunction

    function automatic int natural_len(codepoint_t cp);
        if (cp < CP_MIN2)
            return 1;
        else if (cp < CP_MIN3)
            return 2;
        else if (cp < CP_MIN4)
            return 3;
        return 4;
    endfunction

    function automatic void put_codepoint(codepoint_t cp, int len);
        case (len)
            1:
            begin
                draft.push_back({1'b0, cp[6:0]});
            end
            2:
            begin
                draft.push_back({3'b110, cp[10:6]});
                draft.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                draft.push_back({4'b1110, cp[15:12]});
                draft.push_back({2'b10, cp[11:6]});
                draft.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                draft.push_back({5'b11110, cp[20:18]});
                draft.push_back({2'b10, cp[17:12]});
                draft.push_back({2'b10, cp[11:6]});
                draft.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic void add_unit();
        int         pick;
        int         len;
        codepoint_t cp;
        pick = $urandom_range(99);
        len  = $urandom_range(4, 2);
        if (pick < 30)
        begin
            case ($urandom_range(3))
                0: cp = span_pick(CP_LOWER_LO, CP_LOWER_HI);
                1: cp = span_pick(CP_UPPER_LO, CP_UPPER_HI);
                2: cp = span_pick(CP_DIGIT_LO, CP_DIGIT_HI);
                default: cp = CP_APOSTROPHE;
            endcase
            put_codepoint(cp, 1);
        end
        else if (pick < 40)
            put_codepoint(codepoint_t'($urandom_range(127)), 1);
        else if (pick < 55)
        begin
            case ($urandom_range(4))
                0: cp = span_pick(IDEO_A_LO, IDEO_A_HI);
                1: cp = span_pick(IDEO_U_LO, IDEO_U_HI);
                2: cp = span_pick(IDEO_B_LO, IDEO_B_HI);
                3: cp = span_pick(IDEO_CF_LO, IDEO_CF_HI);
                default: cp = span_pick(IDEO_S_LO, IDEO_S_HI);
            endcase
            put_codepoint(cp, natural_len(cp));
        end
        else if (pick < 63)
        begin
            cp = PUNCT_LIST[$urandom_range(PUNCT_NUM - 1)];
            put_codepoint(cp, natural_len(cp));
        end
        else if (pick < 73)
            put_codepoint(span_pick(first_of_len(len), last_of_len(len)), len);
        else if (pick < 80)
        begin
            cp = EDGE_POINTS[$urandom_range(EDGE_NUM - 1)];
            put_codepoint(cp, natural_len(cp));
        end
        else
        begin
            case ($urandom_range(6))
                0: put_codepoint(codepoint_t'($urandom_range(first_of_len(len) - 1)), len);
                1: put_codepoint(span_pick(SURR_LO, SURR_HI), 3);
                2: put_codepoint(span_pick(CP_MAX + 1'b1, '1), 4);
                3: draft.push_back(byte_t'($urandom_range(8'hBF, 8'h80)));
                4: draft.push_back(byte_t'($urandom_range(8'hFF, 8'hF8)));
                5:
                begin
                    put_codepoint(span_pick(first_of_len(len), last_of_len(len)), len);
                    repeat ($urandom_range(len - 1, 1))
                        void'(draft.pop_back());
                end
                default: draft.push_back(byte_t'($urandom_range(255)));
            endcase
        end
    endfunction

    function automatic void add_text(int max_units);
        int units;
        draft.delete();
        if ($urandom_range(19) == 0)
            units = $urandom_range(60, 1);
        else
            units = $urandom_range(max_units, 1);
        repeat (units)
            add_unit();
        for (int k = 0; k < draft.size(); k++)
            pending_words.push_back({draft[k], logic'(k == draft.size() - 1)});
    endfunction

    function automatic void check_field(string field, count_word_t seen, count_word_t want);
        if (seen !== want)
        begin
            if (errors < 10)
                $display("mismatch on %s: expected %0d, got %0d", field, want, seen);
            errors++;
        end
    endfunction

    function automatic void check_tally();
        tally_t want;
        if (expected_tallies.size() == 0)
        begin
            if (errors < 10)
                $display("unexpected count word: codepoint_count %0d", counts.codepoint_count);
            errors++;
            return;
        end
        want = expected_tallies.pop_front();
        check_field("ideograph_count", counts.ideograph_count, want.ideographs);
        check_field("punct_count", counts.punct_count, want.puncts);
        check_field("word_count", counts.word_count, want.words);
        check_field("word_char_count", counts.word_char_count, want.word_chars);
        check_field("codepoint_count", counts.codepoint_count, want.codepoints);
    endfunction

    task automatic run_phase(int send_pct, int recv_pct, int word_goal, int max_units,
                             logic with_hold);
        @(negedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (pending_words.size() < word_goal)
            add_text(max_units);
        if (with_hold)
        begin
            hold_request = 1'b1;
            @(negedge clk);
            hold_request = 1'b0;
        end
        while (pending_words.size() != 0 || text.valid || expected_tallies.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text.valid      <= 1'b0;
            text.byte_value <= '0;
            text.last_byte  <= 1'b0;
        end
        else
        begin
            if (text.valid && text.ready)
                absorb_word({text.byte_value, text.last_byte});
            if (!text.valid || text.ready)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    outgoing = pending_words.pop_front();
                    text.valid      <= 1'b1;
                    text.byte_value <= outgoing.value;
                    text.last_byte  <= outgoing.last;
                end
                else
                    text.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_request)
            hold_left <= HOLD_CYCLES;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            counts.ready <= 1'b0;
        else
        begin
            if (counts.valid && counts.ready)
                check_tally();
            counts.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        reset_predictor();
        for (int k = 0; k < OPENING_LEN; k++)
            pending_words.push_back({OPENING_TEXT[k], logic'(k == OPENING_LEN - 1)});
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        run_phase(0, 0, 0, 1, 1'b0);
        run_phase(0, 0, 450, 12, 1'b0);
        run_phase(72, 0, 450, 12, 1'b0);
        run_phase(0, 72, 450, 12, 1'b0);
        run_phase(29, 29, 450, 12, 1'b0);
        run_phase(0, 0, 200, 2, 1'b1);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/u8tc_pkg.sv
src/u8tc_byte_if.sv
src/u8tc_count_if.sv
src/utf8_text_class_counter_core.sv
dv/testbench.sv
